FILE: hw/rtl/cdn_pkg.sv
`timescale 1ns / 1ps
package cdn_pkg;

   localparam int unsigned WORK_W      = 17;
   localparam int unsigned DVS_W       = 10;
   localparam int unsigned REC_W       = 14;
   localparam int unsigned RECIP_SHIFT = 17;

   localparam logic [DVS_W-1:0] MS_PER_SEC   = 10'd1000;
   localparam logic [DVS_W-1:0] SEC_PER_MIN  = 10'd60;
   localparam logic [DVS_W-1:0] MIN_PER_HOUR = 10'd60;
   localparam logic [DVS_W-1:0] HOUR_PER_DAY = 10'd24;
   localparam logic [DVS_W-1:0] MON_PER_YEAR = 10'd12;
   localparam logic [DVS_W-1:0] LEAP_CYCLE   = 10'd400;
   localparam logic [14:0]      YEAR_SPAN    = 15'd10000;

   // floor(2^17 / divisor); estimate is low by at most one for 17-bit dividends
   localparam logic [REC_W-1:0] MS_RECIP    = 14'd131;
   localparam logic [REC_W-1:0] MIN_RECIP   = 14'd2184;
   localparam logic [REC_W-1:0] DAY_RECIP   = 14'd5461;
   localparam logic [REC_W-1:0] YEAR_RECIP  = 14'd10922;
   localparam logic [REC_W-1:0] LEAP_RECIP  = 14'd327;

   typedef struct packed {
      logic              start;
      logic [WORK_W-1:0] dividend;
      logic [DVS_W-1:0]  divisor;
      logic [REC_W-1:0]  recip;
   } div_req_type;

   typedef struct packed {
      logic              done;
      logic [WORK_W-1:0] quotient;
      logic [DVS_W-1:0]  remainder;
   } div_rsp_type;

   function automatic logic [4:0] month_len(input logic [3:0] mo, input logic leap);
      logic [4:0] len;
      case (mo)
         4'd2:                      len = leap ? 5'd29 : 5'd28;
         4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
         default:                   len = 5'd31;
      endcase
      return len;
   endfunction

endpackage

FILE: hw/rtl/cdn_divider.sv
`timescale 1ns / 1ps
// Reciprocal divider: estimate by multiply, back-multiply, one correction step.
// One multiplier serves both products; done rises after the quotient, remainder and fix steps.
module cdn_divider (
   input  logic                clock,
   input  logic                reset,
   input  cdn_pkg::div_req_type div_req,
   output cdn_pkg::div_rsp_type div_rsp
);
   import cdn_pkg::*;

   localparam int unsigned PROD_W = WORK_W + REC_W;

   typedef enum logic [3:0] {
      PH_IDLE = 4'b0001,
      PH_QUOT = 4'b0010,
      PH_REM  = 4'b0100,
      PH_FIX  = 4'b1000
   } phase_type;

   phase_type         phase_ff;
   logic              done_ff;
   logic [WORK_W-1:0] num_ff;
   logic [DVS_W-1:0]  dvs_ff;
   logic [REC_W-1:0]  rcp_ff;
   logic [WORK_W-1:0] quo_ff;
   logic [DVS_W:0]    rem_ff;

   logic [WORK_W-1:0] mul_a;
   logic [REC_W-1:0]  mul_b;
   logic [PROD_W-1:0] prod;
   logic [WORK_W-1:0] part;
   logic              over;

   assign mul_a = (phase_ff == PH_REM) ? quo_ff : num_ff;
   assign mul_b = (phase_ff == PH_REM) ? {{(REC_W-DVS_W){1'b0}}, dvs_ff} : rcp_ff;
   assign prod  = PROD_W'(mul_a) * PROD_W'(mul_b);
   // below twice the divisor, so it fits one bit over the divisor width
   assign part  = num_ff - prod[WORK_W-1:0];
   assign over  = rem_ff >= {1'b0, dvs_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         done_ff  <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         case (phase_ff)
            PH_IDLE: begin
               if (div_req.start) begin
                  num_ff   <= div_req.dividend;
                  dvs_ff   <= div_req.divisor;
                  rcp_ff   <= div_req.recip;
                  phase_ff <= PH_QUOT;
               end
            end
            PH_QUOT: begin
               quo_ff   <= {{(WORK_W-(PROD_W-RECIP_SHIFT)){1'b0}},
                            prod[PROD_W-1:RECIP_SHIFT]};
               phase_ff <= PH_REM;
            end
            PH_REM: begin
               rem_ff   <= part[DVS_W:0];
               phase_ff <= PH_FIX;
            end
            PH_FIX: begin
               if (over) begin
                  quo_ff <= quo_ff + WORK_W'(1);
                  rem_ff <= rem_ff - {1'b0, dvs_ff};
               end
               done_ff  <= 1'b1;
               phase_ff <= PH_IDLE;
            end
            default: phase_ff <= PH_IDLE;
         endcase
      end
   end

   assign div_rsp.done      = done_ff;
   assign div_rsp.quotient  = quo_ff;
   assign div_rsp.remainder = rem_ff[DVS_W-1:0];

endmodule

FILE: hw/rtl/calendar_datetime_normalizer.sv
`timescale 1ns / 1ps
// Channel   Handshake               Payload
// req       req_valid / req_stall   func, years/months/days/hours/minutes/seconds/millis
// rsp       rsp_valid / rsp_stall   year..milli, year_wrapped
//
// A request runs 6 divisions in turn on the shared divider (carries and year mod
// 400), then a day walk with one step per month crossed, then one step per year
// wrap; the next request is taken once the block is back in idle.
// Synchronous reset sets the datetime to 2019-01-01 00:00:00.000.
// The result sits in an output register; the next request is taken while it waits,
// and its final step holds until that register is free.
module calendar_datetime_normalizer (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_func,
   input  logic [13:0] req_years_in,
   input  logic [7:0]  req_months_in,
   input  logic [15:0] req_days_in,
   input  logic [15:0] req_hours_in,
   input  logic [15:0] req_minutes_in,
   input  logic [15:0] req_seconds_in,
   input  logic [15:0] req_millis_in,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [13:0] rsp_year_out,
   output logic [3:0]  rsp_month_out,
   output logic [4:0]  rsp_day_out,
   output logic [4:0]  rsp_hour_out,
   output logic [5:0]  rsp_minute_out,
   output logic [5:0]  rsp_second_out,
   output logic [9:0]  rsp_milli_out,
   output logic        rsp_year_wrapped
);
   import cdn_pkg::*;

   typedef enum logic [4:0] {
      ST_IDLE      = 5'b00001,
      ST_DIV_START = 5'b00010,
      ST_DIV_WAIT  = 5'b00100,
      ST_WALK      = 5'b01000,
      ST_WRAP      = 5'b10000
   } state_type;

   typedef enum logic [2:0] {
      OP_MS, OP_SEC, OP_MIN, OP_HOUR, OP_MONTH, OP_YEAR
   } op_type;

   state_type state_ff, state_in;
   op_type    op_ff;

   logic [14:0]       y_ff;
   logic [8:0]        mo_ff;
   logic [WORK_W-1:0] d_ff, h_ff, mi_ff, s_ff, ms_ff;
   logic [8:0]        r400_ff;
   logic              wrap_ff;

   logic [13:0] cur_year_ff;
   logic [3:0]  cur_month_ff;
   logic [4:0]  cur_day_ff, cur_hour_ff;
   logic [5:0]  cur_minute_ff, cur_second_ff;
   logic [9:0]  cur_milli_ff;
   logic        cur_wrap_ff;
   logic        rsp_valid_ff;

   div_req_type div_req;
   div_rsp_type div_rsp;

   logic        req_take;
   logic        leap;
   logic [4:0]  len;
   logic        out_free;

   cdn_divider u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // r400 tracks year mod 400 through the walk
   assign leap = (r400_ff == 9'd0) ||
                 ((r400_ff[1:0] == 2'd0) && !(r400_ff inside {9'd100, 9'd200, 9'd300}));
   assign len  = month_len(mo_ff[3:0], leap);

   always_comb begin
      div_req.start = (state_ff == ST_DIV_START);
      case (op_ff)
         OP_MS: begin
            div_req.dividend = ms_ff;
            div_req.divisor  = MS_PER_SEC;
            div_req.recip    = MS_RECIP;
         end
         OP_SEC: begin
            div_req.dividend = s_ff;
            div_req.divisor  = SEC_PER_MIN;
            div_req.recip    = MIN_RECIP;
         end
         OP_MIN: begin
            div_req.dividend = mi_ff;
            div_req.divisor  = MIN_PER_HOUR;
            div_req.recip    = MIN_RECIP;
         end
         OP_HOUR: begin
            div_req.dividend = h_ff;
            div_req.divisor  = HOUR_PER_DAY;
            div_req.recip    = DAY_RECIP;
         end
         OP_MONTH: begin
            div_req.dividend = {8'd0, mo_ff - 9'd1};
            div_req.divisor  = MON_PER_YEAR;
            div_req.recip    = YEAR_RECIP;
         end
         OP_YEAR: begin
            div_req.dividend = {2'd0, y_ff};
            div_req.divisor  = LEAP_CYCLE;
            div_req.recip    = LEAP_RECIP;
         end
         default: begin
            div_req.dividend = '0;
            div_req.divisor  = LEAP_CYCLE;
            div_req.recip    = LEAP_RECIP;
         end
      endcase
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:      if (req_take) state_in = ST_DIV_START;
         ST_DIV_START: state_in = ST_DIV_WAIT;
         ST_DIV_WAIT: begin
            if (div_rsp.done) state_in = (op_ff == OP_YEAR) ? ST_WALK : ST_DIV_START;
         end
         ST_WALK:      if (d_ff <= {12'd0, len}) state_in = ST_WRAP;
         ST_WRAP: begin
            if (y_ff < YEAR_SPAN && out_free) state_in = ST_IDLE;
         end
         default:      state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         op_ff         <= OP_MS;
         rsp_valid_ff  <= 1'b0;
         cur_year_ff   <= 14'd2019;
         cur_month_ff  <= 4'd1;
         cur_day_ff    <= 5'd1;
         cur_hour_ff   <= '0;
         cur_minute_ff <= '0;
         cur_second_ff <= '0;
         cur_milli_ff  <= '0;
         cur_wrap_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_WRAP && y_ff < YEAR_SPAN && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end

         case (state_ff)
            ST_IDLE: begin
               if (req_take) begin
                  op_ff   <= OP_MS;
                  wrap_ff <= 1'b0;
                  if (req_func) begin
                     y_ff  <= {1'b0, req_years_in};
                     mo_ff <= (req_months_in == 8'd0) ? 9'd1 : {1'b0, req_months_in};
                     d_ff  <= (req_days_in == 16'd0) ? 17'd1 : {1'b0, req_days_in};
                     h_ff  <= {1'b0, req_hours_in};
                     mi_ff <= {1'b0, req_minutes_in};
                     s_ff  <= {1'b0, req_seconds_in};
                     ms_ff <= {1'b0, req_millis_in};
                  end else begin
                     y_ff  <= {1'b0, req_years_in} + {1'b0, cur_year_ff};
                     mo_ff <= {1'b0, req_months_in} + {5'd0, cur_month_ff};
                     d_ff  <= {1'b0, req_days_in} + {12'd0, cur_day_ff};
                     h_ff  <= {1'b0, req_hours_in} + {12'd0, cur_hour_ff};
                     mi_ff <= {1'b0, req_minutes_in} + {11'd0, cur_minute_ff};
                     s_ff  <= {1'b0, req_seconds_in} + {11'd0, cur_second_ff};
                     ms_ff <= {1'b0, req_millis_in} + {7'd0, cur_milli_ff};
                  end
               end
            end
            ST_DIV_WAIT: begin
               if (div_rsp.done) begin
                  case (op_ff)
                     OP_MS: begin
                        ms_ff <= {7'd0, div_rsp.remainder};
                        s_ff  <= s_ff + div_rsp.quotient;
                        op_ff <= OP_SEC;
                     end
                     OP_SEC: begin
                        s_ff  <= {7'd0, div_rsp.remainder};
                        mi_ff <= mi_ff + div_rsp.quotient;
                        op_ff <= OP_MIN;
                     end
                     OP_MIN: begin
                        mi_ff <= {7'd0, div_rsp.remainder};
                        h_ff  <= h_ff + div_rsp.quotient;
                        op_ff <= OP_HOUR;
                     end
                     OP_HOUR: begin
                        h_ff  <= {7'd0, div_rsp.remainder};
                        d_ff  <= d_ff + div_rsp.quotient;
                        op_ff <= OP_MONTH;
                     end
                     OP_MONTH: begin
                        mo_ff <= {5'd0, div_rsp.remainder[3:0]} + 9'd1;
                        y_ff  <= y_ff + div_rsp.quotient[14:0];
                        op_ff <= OP_YEAR;
                     end
                     OP_YEAR: begin
                        r400_ff <= div_rsp.remainder[8:0];
                     end
                     default: op_ff <= OP_MS;
                  endcase
               end
            end
            ST_WALK: begin
               if (d_ff > {12'd0, len}) begin
                  d_ff <= d_ff - {12'd0, len};
                  if (mo_ff == 9'd12) begin
                     mo_ff   <= 9'd1;
                     y_ff    <= y_ff + 15'd1;
                     r400_ff <= (r400_ff == 9'd399) ? 9'd0 : r400_ff + 9'd1;
                  end else begin
                     mo_ff <= mo_ff + 9'd1;
                  end
               end
            end
            ST_WRAP: begin
               if (y_ff >= YEAR_SPAN) begin
                  y_ff    <= y_ff - YEAR_SPAN;
                  wrap_ff <= 1'b1;
               end else if (out_free) begin
                  cur_year_ff   <= y_ff[13:0];
                  cur_month_ff  <= mo_ff[3:0];
                  cur_day_ff    <= d_ff[4:0];
                  cur_hour_ff   <= h_ff[4:0];
                  cur_minute_ff <= mi_ff[5:0];
                  cur_second_ff <= s_ff[5:0];
                  cur_milli_ff  <= ms_ff[9:0];
                  cur_wrap_ff   <= wrap_ff;
               end
            end
            default: ;
         endcase
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_year_out     = cur_year_ff;
   assign rsp_month_out    = cur_month_ff;
   assign rsp_day_out      = cur_day_ff;
   assign rsp_hour_out     = cur_hour_ff;
   assign rsp_minute_out   = cur_minute_ff;
   assign rsp_second_out   = cur_second_ff;
   assign rsp_milli_out    = cur_milli_ff;
   assign rsp_year_wrapped = cur_wrap_ff;

endmodule
